@@ sv/prs_pkg.sv @@
`default_nettype none

package prs_pkg;

    // Sizing
    localparam int NUM_RAILS    = 8;
    localparam int ADC_BITS     = 12;
    localparam int RAIL_W       = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;
    localparam int SAMPLE_PORTS = 8;
    localparam int RID_W        = 3;
    localparam int MASK_W       = 8;
    localparam int IDX_W        = 8;
    localparam int THR_W        = 12;
    localparam int UPD_W        = 8;
    localparam int TEL_W        = 16;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    // Request codes
    typedef enum logic [1:0] {
        REQ_ENABLE  = 2'd0,
        REQ_DISABLE = 2'd1,
        REQ_TICK    = 2'd2
    } req_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_MASK  = 2'd0,
        KIND_FAULT = 2'd1,
        KIND_TELEM = 2'd2
    } kind_t;

    // Per-rail status
    typedef enum logic [1:0] {
        RS_DISABLED    = 2'd0,
        RS_OK          = 2'd1,
        RS_OVERCURRENT = 2'd2
    } rstat_t;

    // Register map index
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_UPDATE    = 2'd1,
        REG_TELEMETRY = 2'd2
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MASK  = 2'd1,
        S_FAULT = 2'd2,
        S_TELEM = 2'd3
    } state_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [UPD_W-1:0] upd_interval;
        logic [TEL_W-1:0] tel_interval;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic  take;
        logic  rail_clr;
        logic  rail_inc;
        logic  emit;
        kind_t kind;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_is_req;
        logic upd_fire;
        logic tel_fire;
        logic tel_pend;
        logic cur_trip;
        logic rail_last;
        logic slot_free;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/prs_cfg.sv @@
`default_nettype none

module prs_cfg
    import prs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [THR_W-1:0] thr_reg;
    logic [UPD_W-1:0] upd_reg;
    logic [TEL_W-1:0] tel_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(3412);
            upd_reg <= UPD_W'(10);
            tel_reg <= TEL_W'(600);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_THRESHOLD: thr_reg <= pwdata[THR_W-1:0];
                REG_UPDATE:    upd_reg <= pwdata[UPD_W-1:0];
                REG_TELEMETRY: tel_reg <= pwdata[TEL_W-1:0];
                default:       ;
            endcase
        end
    end

    // Readback
    always_comb
    begin
        case (idx)
            REG_THRESHOLD: prdata = DATA_W'(thr_reg);
            REG_UPDATE:    prdata = DATA_W'(upd_reg);
            REG_TELEMETRY: prdata = DATA_W'(tel_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.threshold    = thr_reg;
    assign cfg.upd_interval = upd_reg;
    assign cfg.tel_interval = tel_reg;

endmodule

`default_nettype wire

@@ sv/prs_ctrl.sv @@
`default_nettype none

module prs_ctrl
    import prs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    logic   fault_adv;

    // A rail with no trip is skipped without needing the output slot
    assign fault_adv = !stat.cur_trip || stat.slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_is_req)
                        state_next = S_MASK;
                    else if (stat.upd_fire)
                        state_next = S_FAULT;
                    else if (stat.tel_fire)
                        state_next = S_TELEM;
                end
            end
            S_MASK:
            begin
                if (stat.slot_free)
                    state_next = S_IDLE;
            end
            S_FAULT:
            begin
                if (fault_adv && stat.rail_last)
                    state_next = stat.tel_pend ? S_TELEM : S_IDLE;
            end
            S_TELEM:
            begin
                if (stat.slot_free && stat.rail_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.take     = 1'b0;
        cmd.rail_clr = 1'b0;
        cmd.rail_inc = 1'b0;
        cmd.emit     = 1'b0;
        cmd.kind     = KIND_TELEM;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            S_MASK:
            begin
                cmd.kind = KIND_MASK;
                cmd.emit = stat.slot_free;
            end
            S_FAULT:
            begin
                cmd.kind     = KIND_FAULT;
                cmd.emit     = stat.cur_trip && stat.slot_free;
                cmd.rail_inc = fault_adv;
                cmd.rail_clr = fault_adv && stat.rail_last;
            end
            S_TELEM:
            begin
                cmd.kind     = KIND_TELEM;
                cmd.emit     = stat.slot_free;
                cmd.rail_inc = stat.slot_free;
                cmd.rail_clr = stat.slot_free && stat.rail_last;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_req_to_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && stat.in_is_req) |=> (state_reg == S_MASK))
        else $error("enable/disable did not enter mask state");

    a_telem_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TELEM && stat.slot_free && stat.rail_last)
        |=> (state_reg == S_IDLE))
        else $error("telemetry burst did not end after last rail");
`endif

endmodule

`default_nettype wire

@@ sv/prs_dp.sv @@
`default_nettype none

module prs_dp
    import prs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    input  wire logic [1:0]          req_type,
    input  wire logic [IDX_W-1:0]    rail_index,
    input  wire logic [ADC_BITS-1:0] samples [SAMPLE_PORTS],
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               result_kind,
    output logic [RID_W-1:0]         rail_id,
    output logic [MASK_W-1:0]        pin_mask,
    output logic [1:0]               rail_state,
    output logic                     rail_on,
    output logic [ADC_BITS-1:0]      current_code,
    output logic                     last
);

    // Architectural state
    logic [NUM_RAILS-1:0] drive_reg,  drive_next;
    logic [NUM_RAILS-1:0] en_reg,     en_next;
    rstat_t               status_reg [NUM_RAILS];
    rstat_t               status_next [NUM_RAILS];
    logic [ADC_BITS-1:0]  store_reg  [NUM_RAILS];
    logic [ADC_BITS-1:0]  store_next [NUM_RAILS];
    logic [UPD_W-1:0]     upd_ticks_reg, upd_ticks_next;
    logic [TEL_W-1:0]     tel_ticks_reg, tel_ticks_next;

    // Per-item working state
    logic [NUM_RAILS-1:0] trip_reg, trip_next;
    logic                 tel_pend_reg, tel_pend_next;
    logic [RAIL_W-1:0]    req_rail_reg;
    logic [RAIL_W-1:0]    rail_reg, rail_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           result_kind_reg;
    logic [RID_W-1:0]     rail_id_reg;
    logic [MASK_W-1:0]    pin_mask_reg;
    logic [1:0]           rail_state_reg;
    logic                 rail_on_reg;
    logic [ADC_BITS-1:0]  current_code_reg;
    logic                 last_reg;

    logic                 is_en, is_dis, is_tick, in_range;
    logic [RAIL_W-1:0]    req_rail;
    logic [UPD_W-1:0]     upd_sum;
    logic [TEL_W-1:0]     tel_sum;
    logic                 upd_fire, tel_fire;
    logic [NUM_RAILS-1:0] trip_vec;
    logic [NUM_RAILS-1:0] hi_mask;
    logic [RAIL_W-1:0]    sel;
    rstat_t               sel_status;
    logic                 sel_on;
    logic [ADC_BITS-1:0]  sel_code;
    logic                 last_next;
    logic                 slot_free;

    // Request decode
    assign is_en    = (req_type == REQ_ENABLE);
    assign is_dis   = (req_type == REQ_DISABLE);
    assign is_tick  = (req_type == REQ_TICK);
    assign in_range = (rail_index < IDX_W'(NUM_RAILS));
    assign req_rail = rail_index[RAIL_W-1:0];

    // Interval counters
    assign upd_sum  = UPD_W'(upd_ticks_reg + 1'b1);
    assign tel_sum  = TEL_W'(tel_ticks_reg + 1'b1);
    assign upd_fire = is_tick && (upd_sum >= cfg.upd_interval);
    assign tel_fire = is_tick && (tel_sum >= cfg.tel_interval);

    // Overcurrent compare, one lane per rail
    always_comb
    begin
        for (int i = 0; i < NUM_RAILS; i++)
            trip_vec[i] = en_reg[i] && (samples[i] > cfg.threshold);
    end

    // State update on an accepted item
    always_comb
    begin
        drive_next     = drive_reg;
        en_next        = en_reg;
        status_next    = status_reg;
        store_next     = store_reg;
        upd_ticks_next = upd_ticks_reg;
        tel_ticks_next = tel_ticks_reg;
        trip_next      = trip_reg;
        tel_pend_next  = tel_pend_reg;
        if (cmd.take)
        begin
            trip_next     = '0;
            tel_pend_next = 1'b0;
            if ((is_en || is_dis) && in_range)
            begin
                drive_next[req_rail]  = is_en;
                en_next[req_rail]     = is_en;
                status_next[req_rail] = is_en ? RS_OK : RS_DISABLED;
            end
            if (is_tick)
            begin
                upd_ticks_next = upd_fire ? '0 : upd_sum;
                tel_ticks_next = tel_fire ? '0 : tel_sum;
                tel_pend_next  = tel_fire;
                if (upd_fire)
                begin
                    trip_next = trip_vec;
                    for (int i = 0; i < NUM_RAILS; i++)
                    begin
                        store_next[i] = en_reg[i] ? samples[i] : '0;
                        if (trip_vec[i])
                        begin
                            status_next[i] = RS_OVERCURRENT;
                            en_next[i]     = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Rail scan counter
    always_comb
    begin
        rail_next = rail_reg;
        if (cmd.rail_clr)
            rail_next = '0;
        else if (cmd.rail_inc)
            rail_next = RAIL_W'(rail_reg + 1'b1);
    end

    // Result assembly: every kind reads the post-update state of one rail
    assign sel        = (cmd.kind == KIND_MASK) ? req_rail_reg : rail_reg;
    assign sel_status = status_reg[sel];
    assign sel_on     = en_reg[sel];
    assign sel_code   = store_reg[sel];

    always_comb
    begin
        for (int j = 0; j < NUM_RAILS; j++)
            hi_mask[j] = (RAIL_W'(j) > rail_reg);
    end

    always_comb
    begin
        case (cmd.kind)
            KIND_MASK:  last_next = 1'b1;
            KIND_FAULT: last_next = !tel_pend_reg && ((trip_reg & hi_mask) == '0);
            KIND_TELEM: last_next = (rail_reg == RAIL_W'(NUM_RAILS - 1));
            default:    last_next = 1'b0;
        endcase
    end

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg     <= '0;
            en_reg        <= '0;
            for (int i = 0; i < NUM_RAILS; i++)
            begin
                status_reg[i] <= RS_DISABLED;
                store_reg[i]  <= '0;
            end
            upd_ticks_reg <= '0;
            tel_ticks_reg <= '0;
            trip_reg      <= '0;
            tel_pend_reg  <= 1'b0;
            rail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            drive_reg     <= drive_next;
            en_reg        <= en_next;
            status_reg    <= status_next;
            store_reg     <= store_next;
            upd_ticks_reg <= upd_ticks_next;
            tel_ticks_reg <= tel_ticks_next;
            trip_reg      <= trip_next;
            tel_pend_reg  <= tel_pend_next;
            rail_reg      <= rail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            req_rail_reg <= req_rail;
        if (cmd.emit)
        begin
            result_kind_reg  <= cmd.kind;
            rail_id_reg      <= RID_W'(sel);
            pin_mask_reg     <= MASK_W'(drive_reg);
            rail_state_reg   <= sel_status;
            rail_on_reg      <= sel_on;
            current_code_reg <= sel_code;
            last_reg         <= last_next;
        end
    end

    // Status to controller
    assign stat.in_is_req = (is_en || is_dis) && in_range;
    assign stat.upd_fire  = upd_fire;
    assign stat.tel_fire  = tel_fire;
    assign stat.tel_pend  = tel_pend_reg;
    assign stat.cur_trip  = trip_reg[rail_reg];
    assign stat.rail_last = (rail_reg == RAIL_W'(NUM_RAILS - 1));
    assign stat.slot_free = slot_free;

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign rail_id      = rail_id_reg;
    assign pin_mask     = pin_mask_reg;
    assign rail_state   = rail_state_reg;
    assign rail_on      = rail_on_reg;
    assign current_code = current_code_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_ok_is_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_status == RS_OK) |-> sel_on)
        else $error("rail status ok while its enabled flag is clear");

    a_telem_last_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg && result_kind_reg == KIND_TELEM)
        |-> (rail_id_reg == RID_W'(NUM_RAILS - 1)))
        else $error("telemetry marked last on a rail other than the final one");
`endif

endmodule

`default_nettype wire

@@ sv/power_rail_supervisor.sv @@
// An enable/disable transfer gives its pin mask result from the mask state once the
// output slot is free. When an update fires, a tick walks the rails once for faults, one
// rail a cycle, holding on a tripped rail until its result finds a free slot; then, if
// telemetry fires, 8 telemetry records, one a cycle unless stalled; items wait for idle.
// Reset (rst_n, async, active low) clears all rail state and counters at once.
`default_nettype none

module power_rail_supervisor
    import prs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    // Request channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          req_type,
    input  wire logic [IDX_W-1:0]    rail_index,
    input  wire logic [ADC_BITS-1:0] sample_rail0,
    input  wire logic [ADC_BITS-1:0] sample_rail1,
    input  wire logic [ADC_BITS-1:0] sample_rail2,
    input  wire logic [ADC_BITS-1:0] sample_rail3,
    input  wire logic [ADC_BITS-1:0] sample_rail4,
    input  wire logic [ADC_BITS-1:0] sample_rail5,
    input  wire logic [ADC_BITS-1:0] sample_rail6,
    input  wire logic [ADC_BITS-1:0] sample_rail7,
    // Result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               result_kind,
    output logic [RID_W-1:0]         rail_id,
    output logic [MASK_W-1:0]        pin_mask,
    output logic [1:0]               rail_state,
    output logic                     rail_on,
    output logic [ADC_BITS-1:0]      current_code,
    output logic                     last
);

    cfg_t                cfg;
    cmd_t                cmd;
    stat_t               stat;
    logic [ADC_BITS-1:0] samples [SAMPLE_PORTS];

    assign samples[0] = sample_rail0;
    assign samples[1] = sample_rail1;
    assign samples[2] = sample_rail2;
    assign samples[3] = sample_rail3;
    assign samples[4] = sample_rail4;
    assign samples[5] = sample_rail5;
    assign samples[6] = sample_rail6;
    assign samples[7] = sample_rail7;

    prs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    prs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .rail_index   (rail_index),
        .samples      (samples),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .rail_id      (rail_id),
        .pin_mask     (pin_mask),
        .rail_state   (rail_state),
        .rail_on      (rail_on),
        .current_code (current_code),
        .last         (last)
    );

endmodule

`default_nettype wire
